// ----- rtl/core/cffu_pkg.sv -----
// Shared types and codes for the class-filtered FIFO.
`default_nettype none
package cffu_pkg;

	// Operation codes
	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_ANY     = 2'd1;
	localparam logic [1:0] OP_CAT     = 2'd2;
	localparam logic [1:0] OP_DOG     = 2'd3;

	// Kind codes
	localparam logic [1:0] KIND_CAT = 2'd0;
	localparam logic [1:0] KIND_DOG = 2'd1;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// One stored entry
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] name;
		logic [7:0]  age;
	} entry_t;

	// Broadcast control from the top level to every cell
	typedef struct packed {
		logic       do_enq;
		logic       do_deq;
		logic [1:0] op;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/cffu_ifs.sv -----
// Command and response channel interfaces for the class-filtered FIFO.
`default_nettype none
interface cffu_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [1:0]  animal_kind;
	logic [15:0] animal_name;
	logic [7:0]  animal_age;

	modport source (output valid, operation, animal_kind, animal_name, animal_age,
		input ready);
	modport sink (input valid, operation, animal_kind, animal_name, animal_age,
		output ready);
endinterface

interface cffu_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  out_kind;
	logic [15:0] out_name;
	logic [7:0]  out_age;

	modport source (output valid, status, out_kind, out_name, out_age, input ready);
	modport sink (input valid, status, out_kind, out_name, out_age, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cffu_cell.sv -----
// One slot of the compacting queue chain: holds an entry and shifts toward the head.
`default_nettype none
module cffu_cell
	import cffu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire entry_t     wr_entry,
	input  wire logic       prev_valid,
	input  wire logic       prev_hit,
	input  wire logic       next_valid,
	input  wire entry_t     next_entry,
	input  wire entry_t     sel_in,
	output logic            valid,
	output entry_t          entry,
	output logic            hit,
	output entry_t          sel_out
);

	logic   valid_q;
	entry_t entry_q;
	logic   kind_match;
	logic   hit_here;
	logic   shift;
	logic   enq_here;

	// Match the held entry against the requested kind
	always_comb begin
		case (ctrl.op)
			OP_ANY:  kind_match = 1'b1;
			OP_CAT:  kind_match = (entry_q.kind == KIND_CAT);
			OP_DOG:  kind_match = (entry_q.kind == KIND_DOG);
			default: kind_match = 1'b0;
		endcase
	end

	// First match along the chain wins; it and all later cells shift down
	assign hit_here = ctrl.do_deq & valid_q & kind_match & ~prev_hit;
	assign shift    = ctrl.do_deq & (prev_hit | hit_here);
	assign enq_here = ctrl.do_enq & ~valid_q & prev_valid;

	// Hold, shift in the neighbor, or take a new entry at the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
		end else if (enq_here) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= next_entry;
		end else if (enq_here) begin
			entry_q <= wr_entry;
		end
	end

	// Pass the selected entry along the chain
	assign sel_out = hit_here ? entry_t'(sel_in | entry_q) : sel_in;
	assign hit     = prev_hit | hit_here;
	assign valid   = valid_q;
	assign entry   = entry_q;

endmodule
`default_nettype wire

// ----- rtl/core/class_filtered_fifo_unit.sv -----
// Top level of the class-filtered FIFO: a compacting chain of entry cells.
//
// Usage: commands arrive on cmd (valid/ready), one result per command leaves on rsp.
// Enqueue appends kind, name and age at the tail; status 0, or 2 when the queue is
// full and the entry is dropped. Dequeue-any/cat/dog removes the oldest entry of
// that class and returns it with status 0, or status 1 and zero fields if none.
// The result is registered and shows on rsp in the cycle after the command transfer.
// Throughput: one command per cycle while rsp.ready stays high; each cell finds the
// first match by a priority ripple along the chain and all later cells shift down
// in that cycle. cmd.ready is high whenever the result register is empty or being
// drained, so a stalled receiver holds the result and blocks further commands until
// it takes it. Reset clears every cell's valid bit and the result valid flag; the
// queue starts empty and is usable in the first cycle after reset.
`default_nettype none
module class_filtered_fifo_unit
	import cffu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	cffu_cmd_if.sink   cmd,
	cffu_rsp_if.source rsp
);

	logic       chain_valid [QUEUE_DEPTH+1:0];
	entry_t     chain_entry [QUEUE_DEPTH:0];
	logic       chain_hit   [QUEUE_DEPTH:0];
	entry_t     chain_sel   [QUEUE_DEPTH:0];
	cell_ctrl_t ctrl;
	entry_t     wr_entry;
	logic       accept;
	logic       full;
	logic       found;
	logic       rsp_valid_q;
	logic [1:0] status_q;
	entry_t     rsp_entry_q;

	assign cmd.ready = ~rsp_valid_q | rsp.ready;
	assign accept    = cmd.valid & cmd.ready;

	// Chain ends: head always sees a valid predecessor, tail shifts in empty
	assign chain_valid[0]             = 1'b1;
	assign chain_valid[QUEUE_DEPTH+1] = 1'b0;
	assign chain_entry[QUEUE_DEPTH]   = '0;
	assign chain_hit[0]               = 1'b0;
	assign chain_sel[0]               = '0;

	assign full  = chain_valid[QUEUE_DEPTH];
	assign found = chain_hit[QUEUE_DEPTH];

	assign wr_entry.kind = cmd.animal_kind;
	assign wr_entry.name = cmd.animal_name;
	assign wr_entry.age  = cmd.animal_age;

	// Broadcast the operation to all cells on a transfer
	assign ctrl.op     = cmd.operation;
	assign ctrl.do_enq = accept & (cmd.operation == OP_ENQUEUE) & ~full;
	assign ctrl.do_deq = accept & (cmd.operation != OP_ENQUEUE);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cffu_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.wr_entry   (wr_entry),
			.prev_valid (chain_valid[i]),
			.prev_hit   (chain_hit[i]),
			.next_valid (chain_valid[i+2]),
			.next_entry (chain_entry[i+1]),
			.sel_in     (chain_sel[i]),
			.valid      (chain_valid[i+1]),
			.entry      (chain_entry[i]),
			.hit        (chain_hit[i+1]),
			.sel_out    (chain_sel[i+1])
		);
	end

	// Result register: load on a command transfer, drop on a response transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (cmd.operation == OP_ENQUEUE) begin
				status_q    <= full ? ST_FULL : ST_OK;
				rsp_entry_q <= '0;
			end else if (found) begin
				status_q    <= ST_OK;
				rsp_entry_q <= chain_sel[QUEUE_DEPTH];
			end else begin
				status_q    <= ST_NONE;
				rsp_entry_q <= '0;
			end
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.out_kind = rsp_entry_q.kind;
	assign rsp.out_name = rsp_entry_q.name;
	assign rsp.out_age  = rsp_entry_q.age;

endmodule
`default_nettype wire
